FILE: hw/rtl/saq_pkg.sv
// Shared types and constants for the slot allocator with free quarantine.
// Used by the register block, controller, datapath and top level.
`timescale 1ns / 1ps
package saq_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 65536;
  localparam int unsigned MAX_BATCH_DEF = 256;
  localparam int unsigned MAX_LOCAL_DEF = 16;

  localparam logic [63:0] SHUFFLE_MUL = 64'h96e5_1baf_02cd_85fd;
  localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OOM     = 2'd1;
  localparam logic [1:0] STAT_DOUBLE  = 2'd2;
  localparam logic [1:0] STAT_INVALID = 2'd3;

  localparam logic [2:0] REG_QMIN    = 3'd0;
  localparam logic [2:0] REG_LMAX    = 3'd1;
  localparam logic [2:0] REG_BATCH   = 3'd2;
  localparam logic [2:0] REG_SHUFFLE = 3'd3;
  localparam logic [2:0] REG_LIMIT   = 3'd4;

  typedef struct packed {
    logic [15:0] quarantine_min;
    logic [4:0]  local_max;
    logic [8:0]  batch_len;
    logic        shuffle_enable;
    logic [16:0] slot_limit;
  } cfg_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_F_CHK, ST_F_WAIT, ST_A_CHK,
    ST_R_INIT, ST_R_FREED, ST_R_FREED_W, ST_R_FRESH, ST_R_FRESH_W, ST_R_PUSH,
    ST_B_FILL, ST_S_LOOP, ST_S_MUL0, ST_S_MUL1, ST_S_MUL2, ST_S_SUM,
    ST_S_CRC, ST_S_DIV, ST_S_RDJ, ST_S_RDN, ST_S_SWAP, ST_S_LAST,
    ST_Q_LINK, ST_Q_LINK_W, ST_Q_LINK_T,
    ST_K_LOOP, ST_K_W, ST_K_MOVE, ST_K_TAIL,
    ST_C_CHK, ST_C_POP, ST_C_W, ST_C_MARK, ST_DONE
  } state_t;

  typedef struct packed {
    state_t op;
    logic   accept;
  } dp_cmd_t;

  typedef struct packed {
    logic free_bad;
    logic link_alloc;
    logic cache_nil;
    logic freed_go;
    logic more;
    logic fresh_nil;
    logic fill_go;
    logic n_zero;
    logic n_gt1;
    logic crc_last;
    logic div_last;
    logic tmp_nil;
    logic move_go;
    logic q_single;
    logic c_single;
  } dp_stat_t;

endpackage

FILE: hw/rtl/saq_regs.sv
// Configuration registers behind the APB-style port.
// Depends on saq_pkg for the register map and cfg_t.
`timescale 1ns / 1ps
module saq_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output saq_pkg::cfg_t       cfg
);
  import saq_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quarantine_min <= 16'd0;
      cfg.local_max      <= 5'd16;
      cfg.batch_len      <= 9'd16;
      cfg.shuffle_enable <= 1'b1;
      cfg.slot_limit     <= 17'd65536;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_QMIN:    cfg.quarantine_min <= pwdata[15:0];
        REG_LMAX:    cfg.local_max      <= pwdata[4:0];
        REG_BATCH:   cfg.batch_len      <= pwdata[8:0];
        REG_SHUFFLE: cfg.shuffle_enable <= pwdata[0];
        REG_LIMIT:   cfg.slot_limit     <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_QMIN:    prdata = {16'd0, cfg.quarantine_min};
      REG_LMAX:    prdata = {27'd0, cfg.local_max};
      REG_BATCH:   prdata = {23'd0, cfg.batch_len};
      REG_SHUFFLE: prdata = {31'd0, cfg.shuffle_enable};
      REG_LIMIT:   prdata = {15'd0, cfg.slot_limit};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

FILE: hw/rtl/saq_ctrl.sv
// Sequencer for requests: walks free, refill, shuffle and grant steps.
// Depends on saq_pkg for state_t and the command/status structs.
`timescale 1ns / 1ps
module saq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                command,
  input  saq_pkg::dp_stat_t   stat,
  output saq_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import saq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = state;
    cmd.accept = start && (state == ST_IDLE);
    busy       = (state != ST_IDLE);
    done       = (state == ST_DONE);
    unique case (state)
      ST_IDLE:      if (start) state_next = (command == CMD_FREE) ? ST_F_CHK : ST_A_CHK;
      ST_F_CHK:     state_next = stat.free_bad ? ST_DONE : ST_F_WAIT;
      ST_F_WAIT:    state_next = ST_DONE;
      ST_A_CHK:     state_next = stat.cache_nil ? ST_R_INIT : ST_C_POP;
      ST_R_INIT:    state_next = ST_R_FREED;
      ST_R_FREED:   state_next = stat.freed_go ? ST_R_FREED_W : ST_R_FRESH;
      ST_R_FREED_W: state_next = ST_R_FREED;
      ST_R_FRESH: begin
        if (!stat.more)         state_next = ST_Q_LINK;
        else if (stat.fresh_nil) state_next = ST_B_FILL;
        else                    state_next = ST_R_FRESH_W;
      end
      ST_R_FRESH_W: state_next = ST_R_PUSH;
      ST_R_PUSH:    state_next = ST_R_FRESH;
      ST_B_FILL: begin
        if (stat.fill_go)     state_next = ST_B_FILL;
        else if (stat.n_zero) state_next = ST_Q_LINK;
        else                  state_next = ST_S_LOOP;
      end
      ST_S_LOOP:    state_next = stat.n_gt1 ? ST_S_MUL0 : ST_S_LAST;
      ST_S_MUL0:    state_next = ST_S_MUL1;
      ST_S_MUL1:    state_next = ST_S_MUL2;
      ST_S_MUL2:    state_next = ST_S_SUM;
      ST_S_SUM:     state_next = ST_S_CRC;
      ST_S_CRC:     if (stat.crc_last) state_next = ST_S_DIV;
      ST_S_DIV:     if (stat.div_last) state_next = ST_S_RDJ;
      ST_S_RDJ:     state_next = ST_S_RDN;
      ST_S_RDN:     state_next = ST_S_SWAP;
      ST_S_SWAP:    state_next = ST_S_LOOP;
      ST_S_LAST:    state_next = ST_R_PUSH;
      ST_Q_LINK:    state_next = stat.tmp_nil ? ST_K_LOOP : ST_Q_LINK_W;
      ST_Q_LINK_W:  state_next = ST_Q_LINK_T;
      ST_Q_LINK_T:  state_next = ST_Q_LINK;
      ST_K_LOOP: begin
        if (!stat.move_go)    state_next = ST_C_CHK;
        else if (stat.q_single) state_next = ST_K_MOVE;
        else                  state_next = ST_K_W;
      end
      ST_K_W:       state_next = ST_K_MOVE;
      ST_K_MOVE:    state_next = ST_K_TAIL;
      ST_K_TAIL:    state_next = ST_K_LOOP;
      ST_C_CHK:     state_next = stat.cache_nil ? ST_DONE : ST_C_POP;
      ST_C_POP:     state_next = stat.c_single ? ST_C_MARK : ST_C_W;
      ST_C_W:       state_next = ST_C_MARK;
      ST_C_MARK:    state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/saq_dp.sv
// Datapath: list pointers, link table and batch store memories, shuffle
// multiplier, CRC32C and remainder units. Depends on saq_pkg.
`timescale 1ns / 1ps
module saq_dp #(
  parameter int unsigned NUM_SLOTS = saq_pkg::NUM_SLOTS_DEF,
  parameter int unsigned MAX_BATCH = saq_pkg::MAX_BATCH_DEF,
  parameter int unsigned MAX_LOCAL = saq_pkg::MAX_LOCAL_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  saq_pkg::cfg_t       cfg,
  input  saq_pkg::dp_cmd_t    cmd,
  input  logic [15:0]         slot_index,
  input  logic [63:0]         random_seed,
  output saq_pkg::dp_stat_t   stat,
  output logic [15:0]         granted_slot,
  output logic [1:0]          status
);
  import saq_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_SLOTS + 2);
  localparam int W  = (LW > 17) ? LW : 17;
  localparam int BW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int NW = $clog2(MAX_BATCH + 1);
  localparam logic [LW-1:0] NIL   = LW'(NUM_SLOTS);
  localparam logic [LW-1:0] ALLOC = LW'(NUM_SLOTS + 1);

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? CRC32C_POLY : 32'd0);
    return r;
  endfunction

  // list state
  logic [LW-1:0] freed_head, fresh_head, bump, qhead, qtail, qlen;
  logic [LW-1:0] chead, ctail, tmp, idx;
  logic [4:0]    grow, lmax, k;
  logic [W-1:0]  diff, i;
  logic [15:0]   slot_r;
  logic [63:0]   seed_base, seed_cur, p0, prod;
  logic [31:0]   p1, p2, crc;
  logic [2:0]    ccnt;
  logic [3:0]    dcnt;
  logic [NW-1:0] n, bsz, rem;

  // clamped configuration
  logic [4:0]    lmax_c;
  logic [8:0]    bs_c;
  logic [LW-1:0] limit_c;
  logic [W-1:0]  want;
  logic [5:0]    grow2;
  logic [NW:0]   div_sh;

  // memories
  logic [LW-1:0] link_mem [NUM_SLOTS];
  logic [AW-1:0] batch_mem [MAX_BATCH];
  logic          link_we, batch_we;
  logic [AW-1:0] link_waddr, link_raddr;
  logic [LW-1:0] link_wdata, link_rd;
  logic [BW-1:0] batch_waddr, batch_raddr;
  logic [AW-1:0] batch_wdata, batch_rd;

  always_comb begin
    if (cfg.local_max == 5'd0)                 lmax_c = 5'd1;
    else if (cfg.local_max > 5'(MAX_LOCAL))    lmax_c = 5'(MAX_LOCAL);
    else                                       lmax_c = cfg.local_max;
    if (!cfg.shuffle_enable)                   bs_c = 9'd1;
    else if (cfg.batch_len == 9'd0)            bs_c = 9'd1;
    else if (cfg.batch_len > 9'(MAX_BATCH))    bs_c = 9'(MAX_BATCH);
    else                                       bs_c = cfg.batch_len;
    if (W'(cfg.slot_limit) > W'(NUM_SLOTS))    limit_c = LW'(NUM_SLOTS);
    else                                       limit_c = LW'(cfg.slot_limit);
    want   = W'(cfg.quarantine_min) + W'(grow);
    grow2  = {grow, 1'b0};
    div_sh = {rem, crc[15]};
  end

  always_comb begin
    stat.free_bad   = W'(slot_r) >= W'(bump);
    stat.link_alloc = (link_rd == ALLOC);
    stat.cache_nil  = (chead == NIL);
    stat.more       = (i < diff);
    stat.freed_go   = stat.more && (freed_head != NIL);
    stat.fresh_nil  = (fresh_head == NIL);
    stat.fill_go    = (n < bsz) && (bump < limit_c);
    stat.n_zero     = (n == '0);
    stat.n_gt1      = (n > NW'(1));
    stat.crc_last   = (ccnt == 3'd7);
    stat.div_last   = (dcnt == 4'd15);
    stat.tmp_nil    = (tmp == NIL);
    stat.move_go    = (k < lmax) && (qhead != NIL);
    stat.q_single   = (qhead == qtail);
    stat.c_single   = (chead == ctail);
  end

  // link table ports
  always_comb begin
    link_we    = 1'b0;
    link_waddr = AW'(idx);
    link_wdata = tmp;
    link_raddr = AW'(slot_r);
    unique case (cmd.op)
      ST_F_WAIT: begin
        link_we    = stat.link_alloc;
        link_waddr = AW'(slot_r);
        link_wdata = freed_head;
      end
      ST_R_FREED_W, ST_R_PUSH: link_we = 1'b1;
      ST_S_SWAP: begin
        link_we    = 1'b1;
        link_wdata = fresh_head;
      end
      ST_Q_LINK_W, ST_K_MOVE: begin
        link_we    = 1'b1;
        link_wdata = NIL;
      end
      ST_Q_LINK_T: begin
        link_we    = (qtail != NIL);
        link_waddr = AW'(qtail);
        link_wdata = idx;
      end
      ST_K_TAIL: begin
        link_we    = (ctail != NIL);
        link_waddr = AW'(ctail);
        link_wdata = idx;
      end
      ST_C_MARK: begin
        link_we    = 1'b1;
        link_wdata = ALLOC;
      end
      ST_R_FREED: link_raddr = AW'(freed_head);
      ST_R_FRESH: link_raddr = AW'(fresh_head);
      ST_Q_LINK:  link_raddr = AW'(tmp);
      ST_K_LOOP:  link_raddr = AW'(qhead);
      ST_C_POP:   link_raddr = AW'(chead);
      default: ;
    endcase
  end

  // batch store ports
  always_comb begin
    batch_we    = 1'b0;
    batch_waddr = BW'(n);
    batch_wdata = AW'(bump);
    batch_raddr = '0;
    unique case (cmd.op)
      ST_B_FILL: batch_we = stat.fill_go;
      ST_S_SWAP: begin
        batch_we    = 1'b1;
        batch_waddr = BW'(rem);
        batch_wdata = batch_rd;
      end
      ST_S_RDJ: batch_raddr = BW'(rem);
      ST_S_RDN: batch_raddr = BW'(n - NW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rd <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (batch_we) batch_mem[batch_waddr] <= batch_wdata;
    batch_rd <= batch_mem[batch_raddr];
  end

  // list pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      freed_head <= NIL;
      fresh_head <= NIL;
      qhead      <= NIL;
      qtail      <= NIL;
      chead      <= NIL;
      ctail      <= NIL;
      bump       <= '0;
      qlen       <= '0;
      grow       <= 5'd1;
    end else begin
      unique case (cmd.op)
        ST_F_WAIT:    if (stat.link_alloc) freed_head <= LW'(slot_r);
        ST_R_FREED_W: freed_head <= link_rd;
        ST_R_FRESH_W: fresh_head <= link_rd;
        ST_B_FILL:    if (stat.fill_go) bump <= bump + LW'(1);
        ST_S_SWAP:    fresh_head <= idx;
        ST_Q_LINK_T: begin
          if (qtail == NIL) qhead <= idx;
          qtail <= idx;
          qlen  <= qlen + LW'(1);
        end
        ST_K_LOOP: begin
          if (stat.move_go) begin
            if (stat.q_single) begin
              qhead <= NIL;
              qtail <= NIL;
            end
          end else begin
            grow <= (grow2 > 6'(lmax)) ? lmax : grow2[4:0];
          end
        end
        ST_K_W:    qhead <= link_rd;
        ST_K_MOVE: qlen <= qlen - LW'(1);
        ST_K_TAIL: begin
          if (ctail == NIL) chead <= idx;
          ctail <= idx;
        end
        ST_C_POP: begin
          if (stat.c_single) begin
            chead <= NIL;
            ctail <= NIL;
          end
        end
        ST_C_W: chead <= link_rd;
        default: ;
      endcase
    end
  end

  // working registers of the current request
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ST_IDLE: begin
        if (cmd.accept) begin
          slot_r       <= slot_index;
          seed_base    <= random_seed;
          granted_slot <= 16'd0;
          status       <= STAT_OK;
        end
      end
      ST_F_CHK:  if (stat.free_bad) status <= STAT_INVALID;
      ST_F_WAIT: if (!stat.link_alloc) status <= STAT_DOUBLE;
      ST_R_INIT: begin
        lmax <= lmax_c;
        diff <= (want > W'(qlen)) ? want - W'(qlen) : '0;
        i    <= '0;
        tmp  <= NIL;
      end
      ST_R_FREED: if (stat.freed_go) idx <= freed_head;
      ST_R_FREED_W, ST_R_PUSH: begin
        tmp <= idx;
        i   <= i + W'(1);
      end
      ST_R_FRESH: begin
        if (stat.more) begin
          if (!stat.fresh_nil) begin
            idx <= fresh_head;
          end else begin
            n        <= '0;
            bsz      <= NW'(bs_c);
            seed_cur <= seed_base;
          end
        end
      end
      ST_B_FILL: if (stat.fill_go) n <= n + NW'(1);
      ST_S_LOOP: if (stat.n_gt1) seed_cur <= seed_cur + 64'd1;
      ST_S_MUL0: p0 <= seed_cur[31:0] * SHUFFLE_MUL[31:0];
      ST_S_MUL1: p1 <= seed_cur[31:0] * SHUFFLE_MUL[63:32];
      ST_S_MUL2: p2 <= seed_cur[63:32] * SHUFFLE_MUL[31:0];
      ST_S_SUM: begin
        prod <= p0 + {p1 + p2, 32'd0};
        crc  <= 32'd0;
        ccnt <= '0;
        rem  <= '0;
        dcnt <= '0;
      end
      ST_S_CRC: begin
        crc  <= crc_byte(crc, prod[7:0]);
        prod <= prod >> 8;
        ccnt <= ccnt + 3'd1;
      end
      // restoring remainder of the low 16 CRC bits by n, MSB first
      ST_S_DIV: begin
        rem  <= (div_sh >= (NW+1)'(n)) ? NW'(div_sh - (NW+1)'(n)) : NW'(div_sh);
        crc  <= crc << 1;
        dcnt <= dcnt + 4'd1;
      end
      ST_S_RDN: idx <= LW'(batch_rd);
      ST_S_SWAP: n <= n - NW'(1);
      ST_S_LAST: idx <= LW'(batch_rd);
      ST_Q_LINK: begin
        if (!stat.tmp_nil) idx <= tmp;
        else               k <= '0;
      end
      ST_Q_LINK_W: tmp <= link_rd;
      ST_K_LOOP: if (stat.move_go) idx <= qhead;
      ST_K_TAIL: k <= k + 5'd1;
      ST_C_CHK:  if (stat.cache_nil) status <= STAT_OOM;
      ST_C_POP:  idx <= chead;
      ST_C_MARK: granted_slot <= 16'(idx);
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/slot_allocator_quarantine.sv
// Slot allocator with free quarantine. A free checks the slot and pushes it onto
// the freed list; an allocate is served from the local cache. A refill takes slots
// from the freed and fresh lists, fills and shuffles a batch of fresh slots (split
// multiply, CRC32C, remainder), quarantines the taken slots and fills the cache.
// One request at a time; done lasts one cycle and the receiver cannot stall.
// Reset clears list pointers, bump and queue length, not the link or batch memories.
`timescale 1ns / 1ps
module slot_allocator_quarantine #(
  parameter int unsigned NUM_SLOTS = saq_pkg::NUM_SLOTS_DEF,
  parameter int unsigned MAX_BATCH = saq_pkg::MAX_BATCH_DEF,
  parameter int unsigned MAX_LOCAL = saq_pkg::MAX_LOCAL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [15:0] slot_index,
  input  logic [63:0] random_seed,
  output logic        done,
  output logic [15:0] granted_slot,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import saq_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  saq_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  saq_ctrl u_ctrl (
    .clk, .rst, .start, .command, .stat, .cmd, .busy, .done
  );

  saq_dp #(
    .NUM_SLOTS(NUM_SLOTS),
    .MAX_BATCH(MAX_BATCH),
    .MAX_LOCAL(MAX_LOCAL)
  ) u_dp (
    .clk, .rst, .cfg, .cmd, .slot_index, .random_seed, .stat,
    .granted_slot, .status
  );

  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy still high after result");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (granted_slot == 16'd0))
    else $error("failed request returned a slot");

endmodule
